[src/assert_macros.svh]
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, ignored while reset is asserted.
`define CCR_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error(msg);

// Clocked property that also holds during reset.
`define CCR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

[src/ccr_pkg.sv]
package ccr_pkg;

  localparam int unsigned MAX_COLUMNS = 8;
  localparam int unsigned MAX_LINES   = 16;
  localparam int unsigned SAMPLE_W    = 10;
  localparam int unsigned LED_COUNT   = 11;

  // change vector: columns, volume, tuning, lines (report order)
  localparam int unsigned CHG_W     = MAX_COLUMNS + 2 + MAX_LINES;
  localparam int unsigned CHG_IDX_W = $clog2(CHG_W);
  localparam int unsigned VOL_POS   = MAX_COLUMNS;
  localparam int unsigned TUN_POS   = MAX_COLUMNS + 1;
  localparam int unsigned LINE_POS  = MAX_COLUMNS + 2;

  localparam logic [SAMPLE_W-1:0] MIN_DELTA_RST = 10'd8;
  localparam logic [7:0]          PISTON_RST    = 8'h7F;
  localparam logic [3:0]          CMD_LED_MAX   = 4'd10;
  localparam logic [2:0]          CMD_RSVD_OK   = 3'b000;

  localparam int unsigned FIFO_DEPTH = 2;

  typedef struct packed {
    logic [CHG_W-1:0]       chg;
    logic [MAX_COLUMNS-1:0] col_lvl;
    logic                   row;
    logic [SAMPLE_W-1:0]    vol;
    logic [SAMPLE_W-1:0]    tun;
    logic [MAX_LINES-1:0]   line_lvl;
    logic [LED_COUNT-1:0]   led;
    logic                   drive_row;
  } tick_t;

  typedef struct packed {
    logic                 msg_valid;
    logic [15:0]          msg_word;
    logic [LED_COUNT-1:0] led;
    logic                 drive_row;
    logic                 last;
  } result_t;

endpackage

[src/ccr_front.sv]
module ccr_front #(
  parameter int unsigned PISTON_COLUMNS = 8,
  parameter int unsigned DIGITAL_LINES  = 7
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          accept_i,
  input  logic [PISTON_COLUMNS-1:0]     piston_columns_i,
  input  logic [DIGITAL_LINES-1:0]      digital_lines_i,
  input  logic [ccr_pkg::SAMPLE_W-1:0]  volume_sample_i,
  input  logic [ccr_pkg::SAMPLE_W-1:0]  tuning_sample_i,
  input  logic                          cmd_valid_i,
  input  logic [7:0]                    cmd_byte_i,
  input  logic                          cfg_we_i,
  input  logic [ccr_pkg::SAMPLE_W-1:0]  cfg_wdata_i,
  output ccr_pkg::tick_t                tick_o
);

  logic [PISTON_COLUMNS-1:0]        piston_q [2];
  logic                             row_q;
  logic [ccr_pkg::SAMPLE_W-1:0]     vol_q, tun_q, delta_q;
  logic [DIGITAL_LINES-1:0]         dig_q;
  logic [ccr_pkg::LED_COUNT-1:0]    led_q, led_d;

  logic [PISTON_COLUMNS-1:0]        col_chg;
  logic [DIGITAL_LINES-1:0]         line_chg;
  logic [ccr_pkg::SAMPLE_W-1:0]     vol_diff, tun_diff;
  logic                             vol_hit, tun_hit, cmd_ok;
  logic [3:0]                       led_num;
  logic [ccr_pkg::MAX_COLUMNS-1:0]  col_chg_ext, col_lvl_ext;
  logic [ccr_pkg::MAX_LINES-1:0]    line_chg_ext, line_lvl_ext;

  always_comb begin
    col_chg  = piston_columns_i ^ piston_q[row_q];
    line_chg = digital_lines_i ^ dig_q;

    vol_diff = (volume_sample_i >= vol_q) ? volume_sample_i - vol_q : vol_q - volume_sample_i;
    tun_diff = (tuning_sample_i >= tun_q) ? tuning_sample_i - tun_q : tun_q - tuning_sample_i;
    vol_hit  = vol_diff > delta_q;
    tun_hit  = tun_diff > delta_q;

    // 000SLLLL with LLLL up to 10, anything else is dropped
    led_num = cmd_byte_i[3:0];
    cmd_ok  = cmd_valid_i && (cmd_byte_i[7:5] == ccr_pkg::CMD_RSVD_OK)
              && (led_num <= ccr_pkg::CMD_LED_MAX);
    led_d = led_q;
    if (cmd_ok) begin
      led_d[led_num] = cmd_byte_i[4];
    end

    col_chg_ext  = '0;
    col_lvl_ext  = '0;
    line_chg_ext = '0;
    line_lvl_ext = '0;
    col_chg_ext[PISTON_COLUMNS-1:0] = col_chg;
    col_lvl_ext[PISTON_COLUMNS-1:0] = piston_columns_i;
    line_chg_ext[DIGITAL_LINES-1:0] = line_chg;
    line_lvl_ext[DIGITAL_LINES-1:0] = digital_lines_i;

    tick_o.chg       = {line_chg_ext, tun_hit, vol_hit, col_chg_ext};
    tick_o.col_lvl   = col_lvl_ext;
    tick_o.row       = row_q;
    tick_o.vol       = volume_sample_i;
    tick_o.tun       = tuning_sample_i;
    tick_o.line_lvl  = line_lvl_ext;
    tick_o.led       = led_d;
    tick_o.drive_row = ~row_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      piston_q[0] <= ccr_pkg::PISTON_RST[PISTON_COLUMNS-1:0];
      piston_q[1] <= ccr_pkg::PISTON_RST[PISTON_COLUMNS-1:0];
      row_q       <= 1'b0;
      vol_q       <= '0;
      tun_q       <= '0;
      dig_q       <= '1;
      led_q       <= '0;
      delta_q     <= ccr_pkg::MIN_DELTA_RST;
    end else begin
      if (cfg_we_i) begin
        delta_q <= cfg_wdata_i;
      end
      if (accept_i) begin
        // every changed bit flips, so the row simply takes the new levels
        piston_q[row_q] <= piston_columns_i;
        row_q           <= ~row_q;
        dig_q           <= digital_lines_i;
        led_q           <= led_d;
        if (vol_hit) begin
          vol_q <= volume_sample_i;
        end
        if (tun_hit) begin
          tun_q <= tuning_sample_i;
        end
      end
    end
  end

endmodule

[src/ccr_fifo.sv]
module ccr_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_i,
  input  ccr_pkg::tick_t wdata_i,
  input  logic           rd_i,
  output ccr_pkg::tick_t rdata_o,
  output logic           full_o,
  output logic           empty_o
);

  localparam int unsigned PtrW = $clog2(ccr_pkg::FIFO_DEPTH);
  localparam int unsigned CntW = $clog2(ccr_pkg::FIFO_DEPTH + 1);

  ccr_pkg::tick_t  mem_q [ccr_pkg::FIFO_DEPTH];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_wr, do_rd;

  assign full_o  = (cnt_q == CntW'(ccr_pkg::FIFO_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_wr) begin
        wptr_q <= (wptr_q == PtrW'(ccr_pkg::FIFO_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (do_rd) begin
        rptr_q <= (rptr_q == PtrW'(ccr_pkg::FIFO_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

[src/ccr_back.sv]
module ccr_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             head_valid_i,
  input  ccr_pkg::tick_t   head_i,
  output logic             head_pop_o,
  input  logic             out_pop_i,
  output logic             out_full_o,
  output ccr_pkg::result_t out_o
);

  localparam int unsigned IdxW = ccr_pkg::CHG_IDX_W;

  logic [ccr_pkg::CHG_W-1:0] done_q, rem, low;
  logic [IdxW-1:0]           idx, line_idx;
  logic                      is_last, load, out_full_q;
  logic [15:0]               word;
  ccr_pkg::result_t          out_q;

  always_comb begin
    rem     = head_i.chg & ~done_q;
    low     = rem & (~rem + 1'b1);
    is_last = ((rem & ~low) == '0);
    idx     = '0;
    for (int i = 0; i < ccr_pkg::CHG_W; i++) begin
      if (low[i]) begin
        idx = idx | IdxW'(i);
      end
    end
    line_idx = idx - IdxW'(ccr_pkg::LINE_POS);

    case (idx) inside
      [0 : ccr_pkg::VOL_POS - 1]: begin
        word = {1'b0, head_i.col_lvl[idx[2:0]], 6'b0, 4'b1000, head_i.row, idx[2:0]};
      end
      ccr_pkg::VOL_POS: begin
        word = {2'b10, 4'b0, head_i.vol};
      end
      ccr_pkg::TUN_POS: begin
        word = {2'b11, 4'b0, head_i.tun};
      end
      default: begin
        word = {1'b0, head_i.line_lvl[line_idx[3:0]], 6'b0, 4'b0, line_idx[3:0]};
      end
    endcase
    if (rem == '0) begin
      word = '0;  // quiet tick
    end
  end

  assign load       = head_valid_i && (!out_full_q || out_pop_i);
  assign head_pop_o = load && is_last;
  assign out_full_o = out_full_q;
  assign out_o      = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q     <= '0;
      out_full_q <= 1'b0;
    end else begin
      if (load) begin
        done_q     <= is_last ? '0 : (done_q | low);
        out_full_q <= 1'b1;
      end else if (out_pop_i) begin
        out_full_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q.msg_valid <= (rem != '0);
      out_q.msg_word  <= word;
      out_q.led       <= head_i.led;
      out_q.drive_row <= head_i.drive_row;
      out_q.last      <= is_last;
    end
  end

endmodule

[src/console_change_reporter_core.sv]
// Scan change reporter.
// Input queue side: a tick word (piston columns of the driven row, digital lines,
// volume and tuning samples, optional command byte) is taken when push is high
// and full is low. The tick is classified at once and its state (piston rows,
// lines, analog values, LED bits, scan row) is updated on that edge.
// Output queue side: while empty is low the oldest result word is on the
// result ports; pop takes it. A tick yields one word per change, in the order
// piston columns, volume, tuning, digital lines, or a single word with
// msg_valid low when nothing changed. last marks the final word of a tick.
// A tick is written into the tick queue; its first word is then loaded into the output register.
// Throughput: one result word per cycle while pop keeps up; a tick yields max(1, changes)
// words (up to 17) from the output sequencer; a two-deep tick queue sits in
// front of it, so push only stalls (full high) when that queue is full.
// If pop stays low the output word holds, the sequencer waits and the queue
// fills. Reset clears the queues, loads the reset state, min delta = 8.
// cfg_we_i writes min_delta at once; write it only while the block is idle.
module console_change_reporter_core #(
  parameter int unsigned PISTON_COLUMNS = 8,
  parameter int unsigned DIGITAL_LINES  = 7
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push,
  output logic                           full,
  input  logic [PISTON_COLUMNS-1:0]      piston_columns_i,
  input  logic [DIGITAL_LINES-1:0]       digital_lines_i,
  input  logic [ccr_pkg::SAMPLE_W-1:0]   volume_sample_i,
  input  logic [ccr_pkg::SAMPLE_W-1:0]   tuning_sample_i,
  input  logic                           cmd_valid_i,
  input  logic [7:0]                     cmd_byte_i,
  input  logic                           cfg_we_i,
  input  logic [ccr_pkg::SAMPLE_W-1:0]   cfg_wdata_i,
  output logic                           empty,
  input  logic                           pop,
  output logic                           msg_valid_o,
  output logic [15:0]                    msg_word_o,
  output logic [ccr_pkg::LED_COUNT-1:0]  led_state_o,
  output logic                           drive_row_o,
  output logic                           last_o
);

  ccr_pkg::tick_t   tick, head;
  ccr_pkg::result_t res;
  logic             accept, head_empty, head_pop, out_full, out_pop;

  assign accept  = push && !full;
  assign out_pop = pop && out_full;

  ccr_front #(
    .PISTON_COLUMNS(PISTON_COLUMNS),
    .DIGITAL_LINES (DIGITAL_LINES)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .piston_columns_i(piston_columns_i),
    .digital_lines_i (digital_lines_i),
    .volume_sample_i (volume_sample_i),
    .tuning_sample_i (tuning_sample_i),
    .cmd_valid_i     (cmd_valid_i),
    .cmd_byte_i      (cmd_byte_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .tick_o          (tick)
  );

  ccr_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (accept),
    .wdata_i(tick),
    .rd_i   (head_pop),
    .rdata_o(head),
    .full_o (full),
    .empty_o(head_empty)
  );

  ccr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_valid_i(!head_empty),
    .head_i      (head),
    .head_pop_o  (head_pop),
    .out_pop_i   (out_pop),
    .out_full_o  (out_full),
    .out_o       (res)
  );

  assign empty       = !out_full;
  assign msg_valid_o = res.msg_valid;
  assign msg_word_o  = res.msg_word;
  assign led_state_o = res.led;
  assign drive_row_o = res.drive_row;
  assign last_o      = res.last;

endmodule

[src/ccr_checker.sv]
`include "assert_macros.svh"

module ccr_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           full,
  input logic                           empty,
  input logic                           pop,
  input logic                           msg_valid_o,
  input logic [15:0]                    msg_word_o,
  input logic [ccr_pkg::LED_COUNT-1:0]  led_state_o,
  input logic                           drive_row_o,
  input logic                           last_o
);

  // a quiet tick is one word, zero, and last
  `CCR_ASSERT(a_quiet_word, clk_i, rst_ni,
    (!empty && !msg_valid_o) |-> (last_o && msg_word_o == 16'h0000),
    "quiet tick word is not a zero last word")

  // words of one tick follow back to back and share LED and row fields
  `CCR_ASSERT(a_tick_fields, clk_i, rst_ni,
    (!empty && pop && !last_o) |=>
      (!empty && $stable(led_state_o) && $stable(drive_row_o)),
    "tick words split or disagree on LED or row fields")

  // analog words carry only the 10-bit sample below the tag bits
  `CCR_ASSERT(a_analog_fmt, clk_i, rst_ni,
    (!empty && msg_valid_o && msg_word_o[15]) |-> (msg_word_o[13:10] == 4'b0000),
    "malformed analog word")

  // a held word does not change
  `CCR_ASSERT(a_hold, clk_i, rst_ni,
    (!empty && !pop) |=> (!empty && $stable(msg_word_o) && $stable(last_o)),
    "result word changed while stalled")

  // queues are clear on the edge after reset is seen
  `CCR_ASSERT_ALWAYS(a_reset_empty, clk_i,
    !rst_ni |=> (empty && !full),
    "queues not cleared in reset")

endmodule

bind console_change_reporter_core ccr_checker u_ccr_checker (.*);

[tb/tb_console_change_reporter_core.sv]
module tb_console_change_reporter_core;

  localparam int unsigned COLS           = 8;
  localparam int unsigned LINES          = 7;
  localparam int unsigned SAMPLE_W       = ccr_pkg::SAMPLE_W;
  localparam int unsigned LED_COUNT      = ccr_pkg::LED_COUNT;
  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned HOLD_CYCLES    = 250;
  localparam int unsigned RANDOM_PHASE   = 55;

  localparam logic CMD_ON  = 1'b1;
  localparam logic CMD_OFF = 1'b0;

  logic                 clk_i            = 1'b0;
  logic                 rst_ni           = 1'b0;
  logic                 push             = 1'b0;
  logic                 full;
  logic [COLS-1:0]      piston_columns_i = '0;
  logic [LINES-1:0]     digital_lines_i  = '0;
  logic [SAMPLE_W-1:0]  volume_sample_i  = '0;
  logic [SAMPLE_W-1:0]  tuning_sample_i  = '0;
  logic                 cmd_valid_i      = 1'b0;
  logic [7:0]           cmd_byte_i       = '0;
  logic                 cfg_we_i         = 1'b0;
  logic [SAMPLE_W-1:0]  cfg_wdata_i      = '0;
  logic                 empty;
  logic                 pop              = 1'b0;
  logic                 msg_valid_o;
  logic [15:0]          msg_word_o;
  logic [LED_COUNT-1:0] led_state_o;
  logic                 drive_row_o;
  logic                 last_o;

  // scan state as the block should hold it
  logic [COLS-1:0]      mdl_pistons [2];
  logic                 mdl_row;
  logic [SAMPLE_W-1:0]  mdl_vol;
  logic [SAMPLE_W-1:0]  mdl_tun;
  logic [LINES-1:0]     mdl_lines;
  logic [LED_COUNT-1:0] mdl_leds;
  logic [SAMPLE_W-1:0]  mdl_min_delta;

  ccr_pkg::result_t pending_msgs [$];
  ccr_pkg::result_t want;
  int unsigned mismatch_count = 0;
  int unsigned ticks_sent     = 0;
  int unsigned words_seen     = 0;
  int unsigned pop_stall      = 0;
  bit          quiet          = 1'b0;
  bit          hold_req       = 1'b0;

  console_change_reporter_core #(
    .PISTON_COLUMNS(COLS),
    .DIGITAL_LINES (LINES)
  ) uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push            (push),
    .full            (full),
    .piston_columns_i(piston_columns_i),
    .digital_lines_i (digital_lines_i),
    .volume_sample_i (volume_sample_i),
    .tuning_sample_i (tuning_sample_i),
    .cmd_valid_i     (cmd_valid_i),
    .cmd_byte_i      (cmd_byte_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .empty           (empty),
    .pop             (pop),
    .msg_valid_o     (msg_valid_o),
    .msg_word_o      (msg_word_o),
    .led_state_o     (led_state_o),
    .drive_row_o     (drive_row_o),
    .last_o          (last_o)
  );

  always #4 clk_i = ~clk_i;

  task automatic flag_mismatch(input string what);
    mismatch_count++;
    $display("MISMATCH at %0t: %s", $time, what);
  endtask

  function automatic bit exceeds_delta(logic [SAMPLE_W-1:0] a, logic [SAMPLE_W-1:0] b);
    logic [SAMPLE_W-1:0] d;
    d = (a >= b) ? a - b : b - a;
    return d > mdl_min_delta;
  endfunction

  // Updates the scan state for one accepted tick and queues its words.
  task automatic predict_tick(input logic [COLS-1:0] cols, input logic [LINES-1:0] lines,
                              input logic [SAMPLE_W-1:0] vol, input logic [SAMPLE_W-1:0] tun,
                              input logic cv, input logic [7:0] cb);
    logic [15:0]      words [$];
    logic             r;
    ccr_pkg::result_t e;
    int               c;
    int               i;
    r = mdl_row;
    for (c = 0; c < COLS; c++) begin
      if (cols[c] != mdl_pistons[r][c]) begin
        words.push_back({1'b0, cols[c], 6'b0, 1'b1, 3'b0, r, c[2:0]});
        mdl_pistons[r][c] = cols[c];
      end
    end
    mdl_row = ~r;
    if (exceeds_delta(vol, mdl_vol)) begin
      mdl_vol = vol;
      words.push_back({1'b1, 1'b0, 4'b0, vol});
    end
    if (exceeds_delta(tun, mdl_tun)) begin
      mdl_tun = tun;
      words.push_back({1'b1, 1'b1, 4'b0, tun});
    end
    for (i = 0; i < LINES; i++) begin
      if (lines[i] != mdl_lines[i]) begin
        mdl_lines[i] = lines[i];
        words.push_back({1'b0, lines[i], 6'b0, 4'b0, 4'(i)});
      end
    end
    if (cv && cb[7:5] == ccr_pkg::CMD_RSVD_OK && cb[3:0] <= ccr_pkg::CMD_LED_MAX)
      mdl_leds[cb[3:0]] = cb[4];
    e.led       = mdl_leds;
    e.drive_row = mdl_row;
    if (words.size() == 0) begin
      e.msg_valid = 1'b0;
      e.msg_word  = '0;
      e.last      = 1'b1;
      pending_msgs.push_back(e);
    end else begin
      foreach (words[k]) begin
        e.msg_valid = 1'b1;
        e.msg_word  = words[k];
        e.last      = (k == words.size() - 1);
        pending_msgs.push_back(e);
      end
    end
  endtask

  // Offers one tick; entered and left at a falling edge.
  task automatic send_tick(input logic [COLS-1:0] cols, input logic [LINES-1:0] lines,
                           input logic [SAMPLE_W-1:0] vol, input logic [SAMPLE_W-1:0] tun,
                           input logic cv, input logic [7:0] cb);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      push = 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk_i);
    end
    push             = 1'b1;
    piston_columns_i = cols;
    digital_lines_i  = lines;
    volume_sample_i  = vol;
    tuning_sample_i  = tun;
    cmd_valid_i      = cv;
    cmd_byte_i       = cb;
    do @(posedge clk_i); while (full);
    predict_tick(cols, lines, vol, tun, cv, cb);
    ticks_sent++;
    @(negedge clk_i);
  endtask

  // Tick that repeats the stored state, so only the command can matter.
  task automatic send_steady(input logic cv, input logic [7:0] cb);
    send_tick(mdl_pistons[mdl_row], mdl_lines, mdl_vol, mdl_tun, cv, cb);
  endtask

  task automatic wait_until_drained();
    push = 1'b0;
    while (pending_msgs.size() != 0) @(negedge clk_i);
    repeat (3) @(negedge clk_i);
  endtask

  task automatic write_min_delta(input logic [SAMPLE_W-1:0] value);
    wait_until_drained();
    cfg_we_i    = 1'b1;
    cfg_wdata_i = value;
    @(negedge clk_i);
    cfg_we_i      = 1'b0;
    mdl_min_delta = value;
  endtask

  // Mostly plausible scans: a few columns/lines move, pots drift; some pure noise.
  task automatic send_random_tick();
    logic [COLS-1:0]     cols;
    logic [LINES-1:0]    lines;
    logic [SAMPLE_W-1:0] vol;
    logic [SAMPLE_W-1:0] tun;
    logic                cv;
    logic [7:0]          cb;
    int                  v;
    int                  t;
    if ($urandom_range(0, 7) == 0) begin
      cols  = COLS'($urandom);
      lines = LINES'($urandom);
      vol   = SAMPLE_W'($urandom);
      tun   = SAMPLE_W'($urandom);
      cv    = 1'($urandom);
      cb    = 8'($urandom);
    end else begin
      cols  = mdl_pistons[mdl_row];
      lines = mdl_lines;
      for (int c = 0; c < COLS; c++) if ($urandom_range(0, 9) == 0) cols[c] = ~cols[c];
      for (int i = 0; i < LINES; i++) if ($urandom_range(0, 11) == 0) lines[i] = ~lines[i];
      v = int'(mdl_vol) + int'($urandom_range(0, 40)) - 20;
      t = int'(mdl_tun) + int'($urandom_range(0, 40)) - 20;
      if ($urandom_range(0, 5) == 0) v = int'($urandom_range(0, 1023));
      if ($urandom_range(0, 5) == 0) t = int'($urandom_range(0, 1023));
      v   = (v < 0) ? 0 : (v > 1023) ? 1023 : v;
      t   = (t < 0) ? 0 : (t > 1023) ? 1023 : t;
      vol = v[SAMPLE_W-1:0];
      tun = t[SAMPLE_W-1:0];
      cv  = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 4) == 0) cb = 8'($urandom);
      else cb = {ccr_pkg::CMD_RSVD_OK, 1'($urandom), 4'($urandom_range(0, 10))};
    end
    send_tick(cols, lines, vol, tun, cv, cb);
  endtask

  task automatic test_steady_ticks();
    send_tick(ccr_pkg::PISTON_RST, '1, '0, '0, 1'b0, 8'h00);
    send_tick(ccr_pkg::PISTON_RST, '1, '0, '0, 1'b0, 8'h00);
    // a step equal to the threshold stays silent, one more is reported
    send_tick(ccr_pkg::PISTON_RST, '1, ccr_pkg::MIN_DELTA_RST, ccr_pkg::MIN_DELTA_RST,
              1'b0, 8'h00);
    send_tick(ccr_pkg::PISTON_RST, '1, ccr_pkg::MIN_DELTA_RST + 10'd1,
              ccr_pkg::MIN_DELTA_RST + 10'd1, 1'b0, 8'h00);
  endtask

  task automatic test_piston_edges();
    send_tick(8'hFF, mdl_lines, mdl_vol, mdl_tun, 1'b0, 8'h00);
    send_tick(8'h00, mdl_lines, mdl_vol, mdl_tun, 1'b0, 8'h00);
    send_tick(8'h00, mdl_lines, mdl_vol, mdl_tun, 1'b0, 8'h00);
    send_tick(8'hFF, mdl_lines, mdl_vol, mdl_tun, 1'b0, 8'h00);
  endtask

  // every column, both pots and every line change: seventeen words
  task automatic test_full_tick();
    repeat (2) begin
      send_tick(~mdl_pistons[mdl_row], ~mdl_lines,
                (mdl_vol < 10'd512) ? 10'd1023 : 10'd0,
                (mdl_tun < 10'd512) ? 10'd1023 : 10'd0, 1'b0, 8'h00);
    end
  endtask

  task automatic test_led_commands();
    send_steady(1'b1, {ccr_pkg::CMD_RSVD_OK, CMD_ON, 4'd0});
    send_steady(1'b1, {ccr_pkg::CMD_RSVD_OK, CMD_ON, ccr_pkg::CMD_LED_MAX});
    // reserved high bits set: dropped
    send_steady(1'b1, {3'b001, CMD_ON, 4'd5});
    send_steady(1'b1, {3'b111, CMD_OFF, 4'd0});
    send_steady(1'b1, {3'b010, CMD_OFF, ccr_pkg::CMD_LED_MAX});
    // LED number past the last LED: dropped
    send_steady(1'b1, {ccr_pkg::CMD_RSVD_OK, CMD_ON, 4'd11});
    send_steady(1'b1, {ccr_pkg::CMD_RSVD_OK, CMD_ON, 4'd15});
    // byte without its valid flag: dropped
    send_steady(1'b0, {ccr_pkg::CMD_RSVD_OK, CMD_OFF, 4'd0});
    send_steady(1'b1, {ccr_pkg::CMD_RSVD_OK, CMD_OFF, ccr_pkg::CMD_LED_MAX});
  endtask

  task automatic test_min_delta_extremes();
    write_min_delta('0);
    send_tick(mdl_pistons[mdl_row], mdl_lines, mdl_vol + 10'd1, mdl_tun - 10'd1, 1'b0, 8'h00);
    write_min_delta('1);
    send_tick(mdl_pistons[mdl_row], mdl_lines, ~mdl_vol, ~mdl_tun, 1'b0, 8'h00);
    write_min_delta(ccr_pkg::MIN_DELTA_RST);
  endtask

  // output side stalls for a long stretch while ticks keep coming
  task automatic test_backpressure();
    @(posedge clk_i);
    hold_req = 1'b1;
    @(negedge clk_i);
    repeat (15) begin
      send_tick(COLS'($urandom), LINES'($urandom), SAMPLE_W'($urandom), SAMPLE_W'($urandom),
                1'($urandom), 8'($urandom));
    end
  endtask

  task automatic test_random_traffic();
    write_min_delta('0);
    repeat (RANDOM_PHASE) send_random_tick();
    write_min_delta('1);
    repeat (RANDOM_PHASE) send_random_tick();
    write_min_delta(SAMPLE_W'($urandom_range(1, 1022)));
    repeat (RANDOM_PHASE) send_random_tick();
    write_min_delta(10'd3);
    repeat (RANDOM_PHASE) send_random_tick();
    write_min_delta(ccr_pkg::MIN_DELTA_RST);
    @(posedge clk_i);
    quiet = 1'b1;
    @(negedge clk_i);
    repeat (RANDOM_PHASE) send_random_tick();
  endtask

  // receiver: random stall bursts, the long hold when asked, none once quiet
  always @(negedge clk_i) begin
    if (hold_req) begin
      pop_stall = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (pop_stall > 0) begin
      pop = 1'b0;
      pop_stall--;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      pop       = 1'b0;
      pop_stall = $urandom_range(0, 9);
    end else begin
      pop = 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      words_seen++;
      if (pending_msgs.size() == 0) begin
        flag_mismatch($sformatf("word %h arrived with nothing pending", msg_word_o));
      end else begin
        want = pending_msgs.pop_front();
        if (msg_valid_o !== want.msg_valid)
          flag_mismatch($sformatf("msg_valid %b, wanted %b", msg_valid_o, want.msg_valid));
        if (msg_word_o !== want.msg_word)
          flag_mismatch($sformatf("msg_word %h, wanted %h", msg_word_o, want.msg_word));
        if (led_state_o !== want.led)
          flag_mismatch($sformatf("led_state %h, wanted %h", led_state_o, want.led));
        if (drive_row_o !== want.drive_row)
          flag_mismatch($sformatf("drive_row %b, wanted %b", drive_row_o, want.drive_row));
        if (last_o !== want.last)
          flag_mismatch($sformatf("last %b, wanted %b", last_o, want.last));
      end
    end
  end

  initial begin
    int unsigned stuck;
    stuck = 0;
    while (stuck < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((push && !full) || (pop && !empty)) stuck = 0;
      else stuck++;
    end
    $display("Timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
    $display("Mismatches found");
    $finish;
  end

  initial begin
    mdl_pistons[0] = ccr_pkg::PISTON_RST[COLS-1:0];
    mdl_pistons[1] = ccr_pkg::PISTON_RST[COLS-1:0];
    mdl_row        = 1'b0;
    mdl_vol        = '0;
    mdl_tun        = '0;
    mdl_lines      = '1;
    mdl_leds       = '0;
    mdl_min_delta  = ccr_pkg::MIN_DELTA_RST;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_steady_ticks();
    test_piston_edges();
    test_full_tick();
    test_led_commands();
    test_min_delta_extremes();
    test_backpressure();
    test_random_traffic();

    wait_until_drained();
    repeat (20) @(negedge clk_i);
    if (pending_msgs.size() != 0)
      flag_mismatch($sformatf("%0d words never arrived", pending_msgs.size()));
    $display("Sent %0d ticks, checked %0d result words", ticks_sent, words_seen);
    $display("Covered full-change ticks, LED commands, min delta 0/3/8/1023/random, long stall");
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+src
src/ccr_pkg.sv
src/ccr_front.sv
src/ccr_fifo.sv
src/ccr_back.sv
src/console_change_reporter_core.sv
src/ccr_checker.sv
tb/tb_console_change_reporter_core.sv
